/* design/fpcb_pkg.sv */
// Shared types, constants and helpers for the five point cross blur.
// No dependencies; used by the top level.
`default_nettype none

package fpcb_pkg;

  // Geometry limits and register defaults
  localparam int MAX_COLS_DEFAULT = 1024;
  localparam int MAX_ROWS_DEFAULT = 4096;
  localparam int ROWS_RESET       = 480;
  localparam int COLS_RESET       = 640;
  localparam int MIN_DIM          = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int ROWS_CFG_W  = 13;
  localparam int COLS_CFG_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLS  = 2'd2;

  localparam logic MODE_COPY = 1'b0;
  localparam logic MODE_BLUR = 1'b1;

  localparam logic [7:0] WHITE = 8'd255;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       run_last;
    logic       frame_end;
  } result_t;

  // floor(x / 5) for an 8-bit value: x * 205 >> 10 is exact over 0..255
  function automatic logic [7:0] div5(input logic [7:0] x);
    logic [17:0] prod;
    prod = 18'(x) * 18'd205;
    return prod[17:10];
  endfunction

endpackage

`default_nettype wire

/* design/fpcb_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered reads.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module fpcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

/* design/five_point_cross_blur.sv */
// Five point cross mean filter over a raster pixel stream, top level.
// Depends on fpcb_pkg (types, constants, div5) and fpcb_ram (line stores).
//
// Pixels enter on the pixel channel (pixel_in, frame_start) in raster order and
// leave filtered on the result channel one row behind; frame_start forces the
// pixel to position (0,0). An input on row r >= 1 gives the output for (r-1, c);
// an input on the last row also gives its own white (blur) or unchanged (copy)
// pixel, so it yields two results. Row 0 yields nothing. run_last marks the
// final result of one input, frame_end the last pixel of a frame.
// A transfer reads both line stores at its edge; the result stage registers
// the transfer and builds the result from the read data, then pushes it into
// an 8-entry queue whose count register raises result_valid. While
// result_ready stays high one pixel per clock is taken; on the last row the
// single queue pop per cycle limits intake, as each pixel there yields two results.
// Reset: counters return to (0,0), registers to blur, 480 rows, 640 columns,
// the queue empties and both ready outputs stay low. Line stores keep contents.
// Stall: when result_ready stays low the queue fills; pixel_ready drops while
// fewer than two free slots remain beyond the item in flight.
`default_nettype none

module five_point_cross_blur #(
  parameter int MAX_COLS = fpcb_pkg::MAX_COLS_DEFAULT,
  parameter int MAX_ROWS = fpcb_pkg::MAX_ROWS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fpcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpcb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel input channel
  input  wire logic                             pixel_valid,
  output logic                                  pixel_ready,
  input  wire logic [7:0]                       pixel_in,
  input  wire logic                             frame_start,
  // result channel
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic      [7:0]                       pixel_out,
  output logic                                  run_last,
  output logic                                  frame_end
);

  localparam int AW = $clog2(MAX_COLS);       // line store address
  localparam int CW = $clog2(MAX_COLS + 1);   // column count, holds MAX_COLS
  localparam int RW = $clog2(MAX_ROWS + 1);   // row count, holds MAX_ROWS
  localparam int ROWS_RST = (fpcb_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS
                                                               : fpcb_pkg::ROWS_RESET;
  localparam int COLS_RST = (fpcb_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                               : fpcb_pkg::COLS_RESET;
  localparam int QD = fpcb_pkg::QUEUE_DEPTH;
  localparam int QA = fpcb_pkg::QUEUE_AW;

  // ---------------------------------------------------------------------
  // Configuration registers; geometry is clamped into 3..MAX on write
  // ---------------------------------------------------------------------
  logic          mode;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [fpcb_pkg::ROWS_CFG_W-1:0] cfg_rows_raw;
  logic [fpcb_pkg::COLS_CFG_W-1:0] cfg_cols_raw;
  logic [RW-1:0] cfg_rows_clamped;
  logic [CW-1:0] cfg_cols_clamped;

  // refuse writes while reset holds the registers
  assign cfg_ready    = !rst;
  assign cfg_rows_raw = cfg_data[fpcb_pkg::ROWS_CFG_W-1:0];
  assign cfg_cols_raw = cfg_data[fpcb_pkg::COLS_CFG_W-1:0];

  always_comb begin
    if (32'(cfg_rows_raw) < fpcb_pkg::MIN_DIM) begin
      cfg_rows_clamped = RW'(fpcb_pkg::MIN_DIM);
    end else if (32'(cfg_rows_raw) > MAX_ROWS) begin
      cfg_rows_clamped = RW'(MAX_ROWS);
    end else begin
      cfg_rows_clamped = RW'(cfg_rows_raw);
    end
    if (32'(cfg_cols_raw) < fpcb_pkg::MIN_DIM) begin
      cfg_cols_clamped = CW'(fpcb_pkg::MIN_DIM);
    end else if (32'(cfg_cols_raw) > MAX_COLS) begin
      cfg_cols_clamped = CW'(MAX_COLS);
    end else begin
      cfg_cols_clamped = CW'(cfg_cols_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= fpcb_pkg::MODE_BLUR;
      rows <= RW'(ROWS_RST);
      cols <= CW'(COLS_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpcb_pkg::REG_FILTER_MODE: mode <= cfg_data[0];
        fpcb_pkg::REG_IMAGE_ROWS:  rows <= cfg_rows_clamped;
        fpcb_pkg::REG_IMAGE_COLS:  cols <= cfg_cols_clamped;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Position counters: resolve the position of the incoming pixel
  // ---------------------------------------------------------------------
  logic [RW-1:0] row_count, row_next;
  logic [CW-1:0] col_count, col_next;
  logic [RW-1:0] row_start, row_bump, row_cur, row_inc;
  logic [CW-1:0] col_start, col_cur, col_inc;
  logic          accept;

  assign accept = pixel_valid && pixel_ready;

  always_comb begin
    row_start = frame_start ? '0 : row_count;
    col_start = frame_start ? '0 : col_count;
    // a column beyond a shrunk width wraps and advances the row
    if (col_start >= cols) begin
      col_cur  = '0;
      row_bump = row_start + RW'(1);
    end else begin
      col_cur  = col_start;
      row_bump = row_start;
    end
    row_cur = (row_bump >= rows) ? '0 : row_bump;
    // advance past this pixel
    col_inc = col_cur + CW'(1);
    row_inc = row_cur + RW'(1);
    if (col_inc >= cols) begin
      col_next = '0;
      row_next = (row_inc >= rows) ? '0 : row_inc;
    end else begin
      col_next = col_inc;
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores. prev holds row r-1 and is written with the new pixel at
  // the transfer edge. older holds row r-2 (left of c: row r-1) and takes
  // the old prev entry from the result stage, at the edge after the transfer.
  // ---------------------------------------------------------------------
  logic [AW-1:0] addr_c, addr_right, addr_left;
  logic [7:0]    prev_centre, prev_right, older_up, older_left;
  logic          s1_valid;
  logic [AW-1:0] s1_addr, s1_addr_left;

  assign addr_c     = col_cur[AW-1:0];
  assign addr_right = addr_c + AW'(1);
  assign addr_left  = addr_c - AW'(1);

  fpcb_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_prev_line (
    .clk    (clk),
    .we     (accept),
    .waddr  (addr_c),
    .wdata  (pixel_in),
    .raddr0 (addr_c),
    .raddr1 (addr_right),
    .rdata0 (prev_centre),
    .rdata1 (prev_right)
  );

  fpcb_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_older_line (
    .clk    (clk),
    .we     (s1_valid),
    .waddr  (s1_addr),
    .wdata  (prev_centre),
    .raddr0 (addr_c),
    .raddr1 (addr_left),
    .rdata0 (older_up),
    .rdata1 (older_left)
  );

  // ---------------------------------------------------------------------
  // Result stage: in the cycle after the transfer, read data is available
  // ---------------------------------------------------------------------
  logic       s1_has_prev, s1_white, s1_last_row, s1_last_col, s1_blur;
  logic [7:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= addr_c;
      s1_addr_left <= addr_left;
      s1_pix       <= pixel_in;
      s1_blur      <= mode;
      s1_has_prev  <= (row_cur != '0);
      s1_white     <= (row_cur == RW'(1)) || (col_cur == '0) ||
                      (col_cur == cols - CW'(1));
      s1_last_row  <= (row_cur == rows - RW'(1));
      s1_last_col  <= (col_cur == cols - CW'(1));
    end
  end

  // The older write of the previous item lands at the same edge this item
  // reads, so the RAM returns stale data there: forward the written value.
  logic          byp_valid;
  logic [AW-1:0] byp_addr;
  logic [7:0]    byp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    byp_addr <= s1_addr;
    byp_data <= prev_centre;
  end

  logic [7:0] up_pix, left_pix, blur_sum, first_pix;
  fpcb_pkg::result_t first_res, second_res;

  assign up_pix   = (byp_valid && byp_addr == s1_addr)      ? byp_data : older_up;
  assign left_pix = (byp_valid && byp_addr == s1_addr_left) ? byp_data : older_left;

  // each term below 52, so the five terms fit in 8 bits
  assign blur_sum = fpcb_pkg::div5(prev_centre) + fpcb_pkg::div5(up_pix) +
                    fpcb_pkg::div5(left_pix) + fpcb_pkg::div5(s1_pix) +
                    fpcb_pkg::div5(prev_right);

  always_comb begin
    if (!s1_blur) begin
      first_pix = prev_centre;
    end else if (s1_white) begin
      first_pix = fpcb_pkg::WHITE;
    end else begin
      first_pix = blur_sum;
    end
    first_res.pixel      = first_pix;
    first_res.run_last   = !s1_last_row;
    first_res.frame_end  = 1'b0;
    second_res.pixel     = s1_blur ? fpcb_pkg::WHITE : s1_pix;
    second_res.run_last  = 1'b1;
    second_res.frame_end = s1_last_col;
  end

  // ---------------------------------------------------------------------
  // Result queue: up to two pushes and one pop per cycle
  // ---------------------------------------------------------------------
  fpcb_pkg::result_t queue [QD];
  logic [QA-1:0] wptr, rptr;
  logic [QA:0]   count, count_next;
  logic          push_first, push_second, pop;
  logic [1:0]    push_n;
  logic [QA+1:0] committed;

  assign push_first  = s1_valid && s1_has_prev;
  assign push_second = s1_valid && s1_last_row;
  assign push_n      = 2'(push_first) + 2'(push_second);
  assign pop         = result_valid && result_ready;
  assign count_next  = count + (QA+1)'(push_n) - (QA+1)'(pop);

  // hold intake while the queue could not absorb this item and the one in flight
  assign committed   = (QA+2)'(count) + (s1_valid ? (QA+2)'(2) : '0);
  assign pixel_ready = !rst && (committed <= (QA+2)'(QD - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QA'(push_n);
      rptr  <= rptr + QA'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_first) begin
      queue[wptr] <= first_res;
    end
    if (push_second) begin
      queue[push_first ? wptr + QA'(1) : wptr] <= second_res;
    end
  end

  assign result_valid = (count != '0);
  assign pixel_out    = queue[rptr].pixel;
  assign run_last     = queue[rptr].run_last;
  assign frame_end    = queue[rptr].frame_end;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QA+1)'(QD))
    else $error("result queue overflow");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    pixel_ready |-> (count <= (QA+1)'(QD - 2)))
    else $error("pixel_ready high without room for two results");

  a_stage_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(pixel_valid && pixel_ready))
    else $error("result stage active without a transfer");

  a_bypass_follows_stage: assert property (@(posedge clk) disable iff (rst)
    byp_valid |-> $past(s1_valid))
    else $error("forwarding valid without an older write");

  a_second_has_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_has_prev && !s1_last_row) |-> (push_n == 2'd1))
    else $error("single result item not counted once");

endmodule

`default_nettype wire

/* bench/fpcb_filter_check.sv */
// Scoreboard for the five point cross blur. It follows register writes and
// pixel transfers, predicts every filtered pixel and checks the result channel.
// Depends on fpcb_pkg for register codes, modes, WHITE and the result layout.
module fpcb_filter_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fpcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpcb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             pixel_valid,
  input  logic                             pixel_ready,
  input  logic [7:0]                       pixel_in,
  input  logic                             frame_start,
  input  logic                             result_valid,
  input  logic                             result_ready,
  input  logic [7:0]                       pixel_out,
  input  logic                             run_last,
  input  logic                             frame_end,
  output int                               mismatches,
  output int                               pending,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]        prev_row  [fpcb_pkg::MAX_COLS_DEFAULT];
  logic [7:0]        older_row [fpcb_pkg::MAX_COLS_DEFAULT];
  logic              blur_on;
  logic [12:0]       rows_reg;
  logic [10:0]       cols_reg;
  int                row_pos;
  int                col_pos;
  fpcb_pkg::result_t due_pixels [$];
  fpcb_pkg::result_t head;

  initial begin
    mismatches = 0;
    checked    = 0;
    pending    = 0;
  end

  function automatic int clamp_dim(input int v, input int hi);
    return (v < fpcb_pkg::MIN_DIM) ? fpcb_pkg::MIN_DIM : (v > hi) ? hi : v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Advance the filter by one input pixel and queue the results it causes.
  task automatic filter_pixel(input logic [7:0] pix, input logic restart);
    int         nrows;
    int         ncols;
    int         r;
    int         c;
    logic [7:0] level;
    nrows = clamp_dim(rows_reg, fpcb_pkg::MAX_ROWS_DEFAULT);
    ncols = clamp_dim(cols_reg, fpcb_pkg::MAX_COLS_DEFAULT);
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
    end
    // a shrunk geometry wraps the position as a row or frame end would
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= nrows) row_pos = 0;
    r = row_pos;
    c = col_pos;

    if (r >= 1) begin
      if (!blur_on) begin
        level = prev_row[c];
      end else if (r == 1 || c == 0 || c == ncols - 1) begin
        level = fpcb_pkg::WHITE;
      end else begin
        level = 8'(prev_row[c] / 5 + older_row[c] / 5 + older_row[c - 1] / 5
                   + pix / 5 + prev_row[c + 1] / 5);
      end
      due_pixels.push_back(fpcb_pkg::result_t'{pixel: level,
                                               run_last: (r != nrows - 1),
                                               frame_end: 1'b0});
    end
    if (r == nrows - 1) begin
      due_pixels.push_back(fpcb_pkg::result_t'{pixel: blur_on ? fpcb_pkg::WHITE : pix,
                                               run_last: 1'b1,
                                               frame_end: (c == ncols - 1)});
    end

    older_row[c] = prev_row[c];
    prev_row[c]  = pix;
    col_pos = c + 1;
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= nrows) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blur_on  = fpcb_pkg::MODE_BLUR;
      rows_reg = 13'(fpcb_pkg::ROWS_RESET);
      cols_reg = 11'(fpcb_pkg::COLS_RESET);
      row_pos  = 0;
      col_pos  = 0;
      due_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpcb_pkg::REG_FILTER_MODE: blur_on  = cfg_data[0];
          fpcb_pkg::REG_IMAGE_ROWS:  rows_reg = cfg_data[12:0];
          fpcb_pkg::REG_IMAGE_COLS:  cols_reg = cfg_data[10:0];
          default: ;
        endcase
      end
      // results belong to older pixels, so compare before predicting
      if (result_valid && result_ready) begin
        if (due_pixels.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing expected", pixel_out));
        end else begin
          head = due_pixels.pop_front();
          checked++;
          if (pixel_out !== head.pixel)
            flag_mismatch($sformatf("pixel_out %0d, expected %0d", pixel_out, head.pixel));
          if (run_last !== head.run_last)
            flag_mismatch($sformatf("run_last %b, expected %b", run_last, head.run_last));
          if (frame_end !== head.frame_end)
            flag_mismatch($sformatf("frame_end %b, expected %b", frame_end, head.frame_end));
        end
      end
      if (pixel_valid && pixel_ready) filter_pixel(pixel_in, frame_start);
    end
    pending <= due_pixels.size();
  end

endmodule

/* bench/tb_five_point_cross_blur.sv */
// Testbench top for five_point_cross_blur: clock, reset, pixel and register
// stimulus, result back-pressure and the final verdict.
// Depends on fpcb_pkg and on fpcb_filter_check, which predicts and compares.
module tb_five_point_cross_blur;
  timeunit 1ns;
  timeprecision 1ps;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             cfg_valid    = 1'b0;
  logic                             cfg_ready;
  logic [fpcb_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [fpcb_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                             pixel_valid  = 1'b0;
  logic                             pixel_ready;
  logic [7:0]                       pixel_in     = '0;
  logic                             frame_start  = 1'b0;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic [7:0]                       pixel_out;
  logic                             run_last;
  logic                             frame_end;

  int mismatches;
  int pending;
  int checked;

  // Stimulus bookkeeping
  int   items_sent   = 0;
  int   random_items = 0;
  int   phases       = 0;
  int   reg_writes   = 0;
  int   cur_cols     = fpcb_pkg::COLS_RESET;  // effective width after clamping
  logic restart_due  = 1'b0;        // width grew: next pixel must open a frame
  logic source_gaps  = 1'b0;
  logic sink_stalls  = 1'b1;
  logic calm         = 1'b0;        // closing stretch: no idling on either side

  // Directed frames, 3 rows of 4 pixels. The blur set mixes extremes so the
  // interior sums on row 1 depend on every neighbour.
  localparam logic [7:0] BLUR_SET [12] = '{8'd255, 8'd0,   8'd255, 8'd0,
                                           8'd0,   8'd255, 8'd255, 8'd128,
                                           8'd255, 8'd255, 8'd0,   8'd4};
  localparam logic [7:0] COPY_SET [12] = '{8'd0,   8'd255, 8'd1,   8'd254,
                                           8'd128, 8'd127, 8'd3,   8'd252,
                                           8'd255, 8'd0,   8'd85,  8'd170};

  five_point_cross_blur dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .run_last     (run_last),
    .frame_end    (frame_end)
  );

  fpcb_filter_check scoreboard (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("tb_five_point_cross_blur NOT OK");
    $finish;
  end

  // Result side: hold ready high in stretches and drop it in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (calm || !sink_stalls || $urandom_range(0, 15) != 0) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end
    end
  end

  // Bias toward black and white so the division and sum extremes come up often.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one pixel and hold it until the transfer. Call at a rising edge;
  // returns at the edge of the transfer with valid still high.
  task automatic push_pixel(input logic [7:0] value, input logic opens_frame);
    pixel_valid <= 1'b1;
    pixel_in    <= value;
    frame_start <= opens_frame;
    do @(posedge clk); while (!pixel_ready);
    items_sent++;
  endtask

  // Stream random pixels; the first one may open a frame, later ones rarely
  // restart the frame in the middle.
  task automatic feed_pixels(input int count, input logic first_opens);
    for (int k = 0; k < count; k++) begin
      if (source_gaps && !calm && $urandom_range(0, 5) == 0) begin
        pixel_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      push_pixel(pick_pixel(), (k == 0) ? first_opens : ($urandom_range(0, 40) == 0));
    end
    pixel_valid <= 1'b0;
  endtask

  // Wait until every predicted result has arrived, then let a row-0 pixel
  // still in the pipeline settle.
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [fpcb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fpcb_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // Drain, then write the registers selected by pick (bit 0 mode, bit 1 rows,
  // bit 2 columns). A wider image reads line store columns never written in
  // the current frame, so flag that the next pixel must open a frame.
  task automatic apply_setup(input logic [fpcb_pkg::CFG_DATA_W-1:0] mode_v,
                             input logic [fpcb_pkg::CFG_DATA_W-1:0] rows_v,
                             input logic [fpcb_pkg::CFG_DATA_W-1:0] cols_v,
                             input logic [2:0] pick);
    int width;
    wait_idle();
    restart_due = 1'b0;
    if (pick[0]) write_reg(fpcb_pkg::REG_FILTER_MODE, mode_v);
    if (pick[1]) write_reg(fpcb_pkg::REG_IMAGE_ROWS, rows_v);
    if (pick[2]) begin
      write_reg(fpcb_pkg::REG_IMAGE_COLS, cols_v);
      width = cols_v[10:0];
      if (width < fpcb_pkg::MIN_DIM) width = fpcb_pkg::MIN_DIM;
      if (width > fpcb_pkg::MAX_COLS_DEFAULT) width = fpcb_pkg::MAX_COLS_DEFAULT;
      restart_due = (width > cur_cols);
      cur_cols = width;
    end
    cfg_valid <= 1'b0;
    phases++;
  endtask

  initial begin
    logic [fpcb_pkg::CFG_DATA_W-1:0] mode_v;
    logic [fpcb_pkg::CFG_DATA_W-1:0] rows_v;
    logic [fpcb_pkg::CFG_DATA_W-1:0] cols_v;
    logic [2:0]                      pick;
    logic                            opens;
    int                              count;
    logic                            first_random;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: blur, 640 columns. Row 0 gives nothing, so the first
    // white results only show up once a full 640-pixel row has gone in.
    source_gaps = 1'b1;
    feed_pixels(fpcb_pkg::COLS_RESET + 5, 1'b0);
    phases++;

    // Blur on a 3x4 frame; rows written below the minimum, columns with
    // junk above bit 10. One frame covers the white border, the first row
    // and the interior sums.
    source_gaps = 1'b0;
    apply_setup(13'(fpcb_pkg::MODE_BLUR), 13'd2, 13'h1804, 3'b111);
    for (int k = 0; k < 12; k++) push_pixel(BLUR_SET[k], k == 0);
    pixel_valid <= 1'b0;

    // Copy mode through a mode write with junk above bit 0; restart the
    // frame on the third pixel; each pixel on the last row gives two results.
    apply_setup(13'h1FFE, 13'd0, 13'd0, 3'b001);
    for (int k = 0; k < 12; k++) push_pixel(COPY_SET[k], k == 0 || k == 2);
    pixel_valid <= 1'b0;

    // Largest geometry: all ones saturates rows to 4096, columns to 1024.
    // A short stretch stays on row 0, so any result would expose a clamp
    // that came out too narrow.
    source_gaps = 1'b1;
    apply_setup(13'(fpcb_pkg::MODE_COPY), 13'h1FFF, 13'h1FFF, 3'b111);
    feed_pixels(24, 1'b1);

    // Random settings on small frames. Most pixels run as plain raster
    // frames; narrowing mid-frame exercises the wrap, and stray frame
    // restarts add noise.
    first_random = 1'b1;
    while (random_items < 60) begin
      mode_v = 13'($urandom);
      case ($urandom_range(0, 9))
        0:       rows_v = 13'($urandom_range(0, 2));
        1:       rows_v = 13'h1FFF;
        2:       rows_v = 13'($urandom);
        default: rows_v = 13'($urandom_range(3, 7));
      endcase
      case ($urandom_range(0, 7))
        0:       cols_v = 13'($urandom_range(0, 2));
        1:       cols_v = {2'($urandom), 11'($urandom_range(3, 12))};
        default: cols_v = 13'($urandom_range(3, 12));
      endcase
      pick = first_random ? 3'b111 : 3'($urandom);
      apply_setup(mode_v, rows_v, cols_v, pick);

      calm        = (random_items >= 40);
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      count       = $urandom_range(6, 16);
      opens       = restart_due || ($urandom_range(0, 3) == 0);
      if (first_random || $urandom_range(0, 9) == 0) begin
        // hold the source until every outstanding result is out
        feed_pixels(count / 2, opens);
        wait_idle();
        feed_pixels(count - count / 2, 1'b0);
      end else begin
        feed_pixels(count, opens);
      end
      random_items += count;
      first_random = 1'b0;
    end

    // Drain with a bound, then allow for the pipeline depth.
    for (int k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (pending != 0) $display("%0d predicted results never arrived", pending);

    $display("Streamed %0d pixels under %0d settings with %0d register writes,",
             items_sent, phases, reg_writes);
    $display("copy and blur, reset width 640 and small frames; %0d filtered pixels compared.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_five_point_cross_blur OK");
    end else begin
      $display("tb_five_point_cross_blur NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
design/fpcb_pkg.sv
design/fpcb_ram.sv
design/five_point_cross_blur.sv
bench/fpcb_filter_check.sv
bench/tb_five_point_cross_blur.sv
